[design/smc_pkg.sv]
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types, constants and the class palette of the mask colorizer.
// ----------------------------------------------------------------------------
package smc_pkg;

   localparam int SCORE_BITS      = 16;
   localparam int PALETTE_ENTRIES = 10;
   localparam int CLASS_BITS      = 4;
   localparam int COUNT_BITS      = 4;
   localparam int CSR_INDEX_BITS  = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BINARY_MODE = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLASS_COUNT = 4'd1;

   localparam logic [COUNT_BITS-1:0] CLASS_COUNT_RESET = 4'd10;
   localparam logic [COUNT_BITS:0]   ENTRIES_LIMIT     = (COUNT_BITS+1)'(PALETTE_ENTRIES);

   localparam logic [7:0] MASK_ON  = 8'd255;
   localparam logic [7:0] MASK_OFF = 8'd0;

   typedef struct packed {
      logic                  binary_mode;
      logic [COUNT_BITS-1:0] class_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0]            byte_first;
      logic [7:0]            byte_second;
      logic [7:0]            byte_third;
      logic [CLASS_BITS-1:0] winning_class;
   } result_type;

   // Colour bytes of each class; a class without an entry is black.
   function automatic result_type palette_lookup(input logic [CLASS_BITS-1:0] idx);
      result_type r;
      r.winning_class = idx;
      case (idx)
         4'd0:    {r.byte_first, r.byte_second, r.byte_third} = {8'd0,   8'd0,   8'd10};
         4'd1:    {r.byte_first, r.byte_second, r.byte_third} = {8'd128, 8'd64,  8'd128};
         4'd2:    {r.byte_first, r.byte_second, r.byte_third} = {8'd0,   8'd0,   8'd142};
         4'd3:    {r.byte_first, r.byte_second, r.byte_third} = {8'd250, 8'd0,   8'd0};
         4'd4:    {r.byte_first, r.byte_second, r.byte_third} = {8'd220, 8'd220, 8'd0};
         4'd5:    {r.byte_first, r.byte_second, r.byte_third} = {8'd220, 8'd20,  8'd60};
         4'd6:    {r.byte_first, r.byte_second, r.byte_third} = {8'd244, 8'd35,  8'd232};
         4'd7:    {r.byte_first, r.byte_second, r.byte_third} = {8'd0,   8'd0,   8'd70};
         4'd8:    {r.byte_first, r.byte_second, r.byte_third} = {8'd0,   8'd60,  8'd100};
         4'd9:    {r.byte_first, r.byte_second, r.byte_third} = {8'd0,   8'd0,   8'd230};
         default: {r.byte_first, r.byte_second, r.byte_third} = {8'd0,   8'd0,   8'd0};
      endcase
      return r;
   endfunction

endpackage

[design/segmentation_mask_colorizer_unit.sv]
// ----------------------------------------------------------------------------
// segmentation_mask_colorizer_unit
// Turns a stream of class scores into palette coloured or binary mask pixels.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  req      in         score (signed Q8.8)
//  rsp      out        byte_first, byte_second, byte_third, winning_class
//  csr      in         csr_index, csr_data (binary_mode, class_count)
//
// One score is taken every cycle unless the input register is held; a pixel
// takes one score per class in class mode, where a class_count of zero counts
// as one and anything above ten as ten, and one score in binary mode. A score
// passes the input register, the argmax compare and the result register. Reset
// clears the valid flags and running maximum and presets the configuration. A
// stalled result holds the input register once it is full; others move on.
module segmentation_mask_colorizer_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [smc_pkg::SCORE_BITS-1:0]    req_score,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [7:0]                               rsp_byte_first,
   output logic [7:0]                               rsp_byte_second,
   output logic [7:0]                               rsp_byte_third,
   output logic [smc_pkg::CLASS_BITS-1:0]           rsp_winning_class,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [smc_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [smc_pkg::COUNT_BITS-1:0]           csr_data
);

   smc_pkg::cfg_type cfg_ff, cfg_in;

   logic                                  hold_valid_ff, hold_valid_in;
   logic signed [smc_pkg::SCORE_BITS-1:0] hold_score_ff;

   logic                emit;
   logic                space;
   logic                advance;
   smc_pkg::result_type result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            smc_pkg::CSR_BINARY_MODE: cfg_in.binary_mode = csr_data[0];
            smc_pkg::CSR_CLASS_COUNT: cfg_in.class_count = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.binary_mode <= 1'b0;
         cfg_ff.class_count <= smc_pkg::CLASS_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The held score moves on when it gives no result or the result has room.
   assign advance       = hold_valid_ff && (!emit || space);
   assign req_ready     = !hold_valid_ff || advance;
   assign hold_valid_in = (req_valid && req_ready) || (hold_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hold_score_ff <= req_score;
      end
   end

   smc_argmax u_argmax (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .step   (advance),
      .score  (hold_score_ff),
      .emit   (emit),
      .result (result)
   );

   smc_result_reg u_result (
      .clock             (clock),
      .reset             (reset),
      .load              (advance && emit),
      .result            (result),
      .space             (space),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_byte_first    (rsp_byte_first),
      .rsp_byte_second   (rsp_byte_second),
      .rsp_byte_third    (rsp_byte_third),
      .rsp_winning_class (rsp_winning_class)
   );

endmodule

[design/smc_argmax.sv]
// ----------------------------------------------------------------------------
// smc_argmax
// Running maximum over the class scores of a pixel, and the binary threshold.
// ----------------------------------------------------------------------------
module smc_argmax (
   input  logic                                clock,
   input  logic                                reset,
   input  smc_pkg::cfg_type                    cfg,
   input  logic                                step,
   input  logic signed [smc_pkg::SCORE_BITS-1:0] score,
   output logic                                emit,
   output smc_pkg::result_type                 result
);

   logic signed [smc_pkg::SCORE_BITS-1:0] best_score_ff, best_score_in;
   logic [smc_pkg::CLASS_BITS-1:0]        best_index_ff, best_index_in;
   logic [smc_pkg::CLASS_BITS-1:0]        class_position_ff, class_position_in;

   logic [smc_pkg::COUNT_BITS:0] count_eff;
   logic [smc_pkg::COUNT_BITS:0] position_next;
   logic                         take;
   logic                         last;

   always_comb begin
      // A count of zero means one class; above the palette it saturates.
      if (cfg.class_count == '0) begin
         count_eff = (smc_pkg::COUNT_BITS+1)'(1);
      end else if ({1'b0, cfg.class_count} > smc_pkg::ENTRIES_LIMIT) begin
         count_eff = smc_pkg::ENTRIES_LIMIT;
      end else begin
         count_eff = {1'b0, cfg.class_count};
      end

      position_next = {1'b0, class_position_ff} + (smc_pkg::COUNT_BITS+1)'(1);
      take          = (class_position_ff == '0) || (score > best_score_ff);
      last          = position_next >= count_eff;

      best_score_in     = best_score_ff;
      best_index_in     = best_index_ff;
      class_position_in = class_position_ff;

      if (cfg.binary_mode) begin
         emit                 = 1'b1;
         result.byte_first    = (score > 0) ? smc_pkg::MASK_ON : smc_pkg::MASK_OFF;
         result.byte_second   = result.byte_first;
         result.byte_third    = result.byte_first;
         result.winning_class = '0;
      end else begin
         if (take) begin
            best_score_in = score;
            best_index_in = class_position_ff;
         end
         emit   = last;
         result = smc_pkg::palette_lookup(best_index_in);
         if (last) begin
            class_position_in = '0;
         end else begin
            class_position_in = position_next[smc_pkg::CLASS_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff     <= '0;
         best_index_ff     <= '0;
         class_position_ff <= '0;
      end else if (step) begin
         best_score_ff     <= best_score_in;
         best_index_ff     <= best_index_in;
         class_position_ff <= class_position_in;
      end
   end

endmodule

[design/smc_result_reg.sv]
// ----------------------------------------------------------------------------
// smc_result_reg
// Result register that holds one mask pixel until the consumer takes it.
// ----------------------------------------------------------------------------
module smc_result_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  smc_pkg::result_type result,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_byte_first,
   output logic [7:0]          rsp_byte_second,
   output logic [7:0]          rsp_byte_third,
   output logic [smc_pkg::CLASS_BITS-1:0] rsp_winning_class
);

   logic                valid_ff, valid_in;
   smc_pkg::result_type data_ff;

   // The register frees up in the same cycle as its content is transferred.
   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_byte_first    = data_ff.byte_first;
   assign rsp_byte_second   = data_ff.byte_second;
   assign rsp_byte_third    = data_ff.byte_third;
   assign rsp_winning_class = data_ff.winning_class;

endmodule
